/* rtl/core/vpid_pkg.sv */
package vpid_pkg;

   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int GAIN_FRAC_BITS_DEF = 8;
   localparam int GAIN_WIDTH         = 16;
   localparam int OUTPUT_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH     = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_PROP      = 3'd0,
      CSR_GAIN_INTEG     = 3'd1,
      CSR_GAIN_DERIV     = 3'd2,
      CSR_OUTPUT_LOW     = 3'd3,
      CSR_OUTPUT_HIGH    = 3'd4,
      CSR_INTEG_LOW      = 3'd5,
      CSR_INTEG_HIGH     = 3'd6,
      CSR_INTEG_LIMIT_ON = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_HIGH = 2'd1,
      CLAMP_LOW  = 2'd2
   } clamp_status_type;

   localparam logic [GAIN_WIDTH-1:0]   GAIN_PROP_RESET  = 16'd256;
   localparam logic [GAIN_WIDTH-1:0]   GAIN_INTEG_RESET = 16'd256;
   localparam logic [GAIN_WIDTH-1:0]   GAIN_DERIV_RESET = 16'd0;
   localparam logic [OUTPUT_WIDTH-1:0] LIMIT_LOW_RESET  = 32'h8000_0000;
   localparam logic [OUTPUT_WIDTH-1:0] LIMIT_HIGH_RESET = 32'h7fff_ffff;

endpackage

/* rtl/core/vpid_intf.sv */
interface vpid_req_if #(
   parameter int SAMPLE_WIDTH = vpid_pkg::SAMPLE_WIDTH_DEF
);
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic signed [SAMPLE_WIDTH-1:0]        setpoint;
   logic signed [SAMPLE_WIDTH-1:0]        measure;
   logic signed [SAMPLE_WIDTH-1:0]        preload_prev_measure;
   logic signed [SAMPLE_WIDTH-1:0]        preload_older_measure;
   logic signed [vpid_pkg::OUTPUT_WIDTH-1:0] preload_output;

   modport source (
      output valid, action, setpoint, measure, preload_prev_measure,
             preload_older_measure, preload_output,
      input  ready
   );
   modport sink (
      input  valid, action, setpoint, measure, preload_prev_measure,
             preload_older_measure, preload_output,
      output ready
   );
endinterface

interface vpid_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vpid_pkg::OUTPUT_WIDTH-1:0] control_out;
   logic [1:0]                            clamp_status;
   logic                                  integ_clamped;

   modport source (
      output valid, control_out, clamp_status, integ_clamped,
      input  ready
   );
   modport sink (
      input  valid, control_out, clamp_status, integ_clamped,
      output ready
   );
endinterface

interface vpid_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [vpid_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [vpid_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

/* rtl/core/velocity_pid_controller.sv */
// channel   direction  contents
// req_chan  in         action, setpoint, measure, preload history and output
// rsp_chan  out        control_out, clamp_status, integ_clamped
// csr_chan  in         register index and write data, always ready
//
// one request per cycle sustained while rsp_chan is ready; a result is registered
// once the input register passes its request on to the result register
// history and held output update in the same cycle the result is registered,
// so a request arriving next cycle sees them
// reset clears handshake state, history, held output and register defaults
// a stalled result holds the result register; the input register still fills if empty
module velocity_pid_controller #(
   parameter int SAMPLE_WIDTH   = vpid_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = vpid_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   vpid_req_if.sink    req_chan,
   vpid_rsp_if.source  rsp_chan,
   vpid_csr_if.sink    csr_chan
);
   import vpid_pkg::*;

   localparam int DIFF_W = SAMPLE_WIDTH + 2;
   localparam int PROD_W = DIFF_W + GAIN_WIDTH + 1;
   localparam int SUM_W  = (PROD_W > 34) ? PROD_W + 2 : 36;

   // configuration registers
   logic        [GAIN_WIDTH-1:0]   gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic signed [OUTPUT_WIDTH-1:0] output_low_ff, output_high_ff;
   logic signed [OUTPUT_WIDTH-1:0] integ_low_ff, integ_high_ff;
   logic                           integ_limit_on_ff;

   // state
   logic signed [SAMPLE_WIDTH-1:0] prev_measure_ff, prev_measure_in;
   logic signed [SAMPLE_WIDTH-1:0] older_measure_ff, older_measure_in;
   logic signed [OUTPUT_WIDTH-1:0] held_output_ff, held_output_in;

   // input register
   logic                           in_valid_ff, in_valid_in;
   logic                           in_action_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_setpoint_ff, in_measure_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_pre_prev_ff, in_pre_older_ff;
   logic signed [OUTPUT_WIDTH-1:0] in_pre_output_ff;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [OUTPUT_WIDTH-1:0] control_out_ff, control_out_in;
   clamp_status_type               clamp_status_ff, clamp_status_in;
   logic                           integ_clamped_ff, integ_clamped_in;

   logic load_req;
   logic advance;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign load_req       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = load_req || (in_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.control_out   = control_out_ff;
   assign rsp_chan.clamp_status  = clamp_status_ff;
   assign rsp_chan.integ_clamped = integ_clamped_ff;

   always_comb begin
      logic signed [DIFF_W-1:0] diff_p;
      logic signed [DIFF_W-1:0] diff_i;
      logic signed [DIFF_W-1:0] diff_d;
      logic signed [PROD_W-1:0] term_p;
      logic signed [PROD_W-1:0] term_i;
      logic signed [PROD_W-1:0] term_d;
      logic signed [SUM_W-1:0]  integ_w;
      logic signed [SUM_W-1:0]  sum_w;

      diff_p = DIFF_W'(prev_measure_ff) - DIFF_W'(in_measure_ff);
      diff_i = DIFF_W'(in_setpoint_ff) - DIFF_W'(in_measure_ff);
      diff_d = DIFF_W'(prev_measure_ff) + diff_p - DIFF_W'(older_measure_ff);

      term_p = (PROD_W'(diff_p) * PROD_W'(signed'({1'b0, gain_prop_ff})))
               >>> GAIN_FRAC_BITS;
      term_i = (PROD_W'(diff_i) * PROD_W'(signed'({1'b0, gain_integ_ff})))
               >>> GAIN_FRAC_BITS;
      term_d = (PROD_W'(diff_d) * PROD_W'(signed'({1'b0, gain_deriv_ff})))
               >>> GAIN_FRAC_BITS;

      integ_w          = SUM_W'(term_i);
      integ_clamped_in = 1'b0;
      if (integ_limit_on_ff) begin
         if (integ_w > SUM_W'(integ_high_ff)) begin
            integ_w          = SUM_W'(integ_high_ff);
            integ_clamped_in = 1'b1;
         end else if (integ_w < SUM_W'(integ_low_ff)) begin
            integ_w          = SUM_W'(integ_low_ff);
            integ_clamped_in = 1'b1;
         end
      end

      sum_w = SUM_W'(held_output_ff) + SUM_W'(term_p) + integ_w + SUM_W'(term_d);

      if (sum_w > SUM_W'(output_high_ff)) begin
         control_out_in  = output_high_ff;
         clamp_status_in = CLAMP_HIGH;
      end else if (sum_w < SUM_W'(output_low_ff)) begin
         control_out_in  = output_low_ff;
         clamp_status_in = CLAMP_LOW;
      end else begin
         control_out_in  = sum_w[OUTPUT_WIDTH-1:0];
         clamp_status_in = CLAMP_NONE;
      end

      prev_measure_in  = in_measure_ff;
      older_measure_in = prev_measure_ff;
      held_output_in   = control_out_in;

      if (in_action_ff) begin
         control_out_in   = in_pre_output_ff;
         clamp_status_in  = CLAMP_NONE;
         integ_clamped_in = 1'b0;
         prev_measure_in  = in_pre_prev_ff;
         older_measure_in = in_pre_older_ff;
         held_output_in   = in_pre_output_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff      <= GAIN_PROP_RESET;
         gain_integ_ff     <= GAIN_INTEG_RESET;
         gain_deriv_ff     <= GAIN_DERIV_RESET;
         output_low_ff     <= LIMIT_LOW_RESET;
         output_high_ff    <= LIMIT_HIGH_RESET;
         integ_low_ff      <= LIMIT_LOW_RESET;
         integ_high_ff     <= LIMIT_HIGH_RESET;
         integ_limit_on_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_GAIN_PROP:      gain_prop_ff      <= csr_chan.data[GAIN_WIDTH-1:0];
            CSR_GAIN_INTEG:     gain_integ_ff     <= csr_chan.data[GAIN_WIDTH-1:0];
            CSR_GAIN_DERIV:     gain_deriv_ff     <= csr_chan.data[GAIN_WIDTH-1:0];
            CSR_OUTPUT_LOW:     output_low_ff     <= csr_chan.data[OUTPUT_WIDTH-1:0];
            CSR_OUTPUT_HIGH:    output_high_ff    <= csr_chan.data[OUTPUT_WIDTH-1:0];
            CSR_INTEG_LOW:      integ_low_ff      <= csr_chan.data[OUTPUT_WIDTH-1:0];
            CSR_INTEG_HIGH:     integ_high_ff     <= csr_chan.data[OUTPUT_WIDTH-1:0];
            CSR_INTEG_LIMIT_ON: integ_limit_on_ff <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         prev_measure_ff  <= '0;
         older_measure_ff <= '0;
         held_output_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            prev_measure_ff  <= prev_measure_in;
            older_measure_ff <= older_measure_in;
            held_output_ff   <= held_output_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_req) begin
         in_action_ff     <= req_chan.action;
         in_setpoint_ff   <= req_chan.setpoint;
         in_measure_ff    <= req_chan.measure;
         in_pre_prev_ff   <= req_chan.preload_prev_measure;
         in_pre_older_ff  <= req_chan.preload_older_measure;
         in_pre_output_ff <= req_chan.preload_output;
      end
      if (advance) begin
         control_out_ff   <= control_out_in;
         clamp_status_ff  <= clamp_status_in;
         integ_clamped_ff <= integ_clamped_in;
      end
   end

endmodule

/* bench/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vpid_pkg::*;

   localparam int GAIN_FRAC   = GAIN_FRAC_BITS_DEF;
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD   = 300;
   localparam int N_PHASES    = 7;
   localparam int PHASE_ITEMS = 225;

   localparam logic ACT_STEP    = 1'b0;
   localparam logic ACT_PRELOAD = 1'b1;

   typedef struct {
      logic                           action;
      logic signed [15:0]             setpoint;
      logic signed [15:0]             measure;
      logic signed [15:0]             pre_prev;
      logic signed [15:0]             pre_older;
      logic signed [OUTPUT_WIDTH-1:0] pre_out;
   } pid_req_type;

   typedef struct {
      logic signed [OUTPUT_WIDTH-1:0] control_out;
      clamp_status_type               status;
      logic                           integ_clamped;
   } pid_result_type;

   typedef logic [CSR_DATA_WIDTH-1:0] reg_set_type [8];

   logic clock = 1'b0;
   logic reset;

   vpid_req_if req_if ();
   vpid_rsp_if rsp_if ();
   vpid_csr_if csr_if ();

   velocity_pid_controller dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // controller state and registers as seen from outside
   logic signed [15:0] hist_prev;
   logic signed [15:0] hist_older;
   int                 held_out;
   int                 gain_p, gain_i, gain_d;
   int                 out_lo, out_hi, integ_lo, integ_hi;
   logic               integ_lim_en;

   pid_result_type pending_outputs[$];
   int             errors = 0;
   int             idle_pct = 0;
   bit             long_hold_req = 1'b0;
   bit             long_hold_done = 1'b0;
   int             hold_left = 0;
   int             quiet_cycles = 0;

   function automatic pid_result_type advance_pid(input pid_req_type r);
      pid_result_type res;
      longint         dp, dd, p, i, d, y;
      res.status        = CLAMP_NONE;
      res.integ_clamped = 1'b0;
      if (r.action == ACT_PRELOAD) begin
         hist_prev       = r.pre_prev;
         hist_older      = r.pre_older;
         held_out        = r.pre_out;
         res.control_out = r.pre_out;
      end else begin
         dp = longint'(hist_prev) - longint'(r.measure);
         dd = longint'(hist_prev) + dp - longint'(hist_older);
         p  = (longint'(gain_p) * dp) >>> GAIN_FRAC;
         i  = (longint'(gain_i) * (longint'(r.setpoint) - longint'(r.measure))) >>> GAIN_FRAC;
         d  = (longint'(gain_d) * dd) >>> GAIN_FRAC;
         if (integ_lim_en) begin
            if (i > longint'(integ_hi)) begin
               i = integ_hi;
               res.integ_clamped = 1'b1;
            end else if (i < longint'(integ_lo)) begin
               i = integ_lo;
               res.integ_clamped = 1'b1;
            end
         end
         y = longint'(held_out) + p + i + d;
         if (y > longint'(out_hi)) begin
            y = out_hi;
            res.status = CLAMP_HIGH;
         end else if (y < longint'(out_lo)) begin
            y = out_lo;
            res.status = CLAMP_LOW;
         end
         held_out        = int'(y);
         hist_older      = hist_prev;
         hist_prev       = r.measure;
         res.control_out = int'(y);
      end
      return res;
   endfunction

   function automatic pid_req_type step_req(input int sp, input int ms);
      pid_req_type r;
      r.action    = ACT_STEP;
      r.setpoint  = sp[15:0];
      r.measure   = ms[15:0];
      r.pre_prev  = '0;
      r.pre_older = '0;
      r.pre_out   = '0;
      return r;
   endfunction

   function automatic pid_req_type preload_req(input int prev, input int older, input int out);
      pid_req_type r;
      r.action    = ACT_PRELOAD;
      r.setpoint  = '0;
      r.measure   = '0;
      r.pre_prev  = prev[15:0];
      r.pre_older = older[15:0];
      r.pre_out   = out;
      return r;
   endfunction

   function automatic pid_req_type rand_pid_req();
      pid_req_type r;
      r.action    = ($urandom_range(0, 99) < 8) ? ACT_PRELOAD : ACT_STEP;
      r.setpoint  = 16'($urandom);
      r.measure   = 16'($urandom);
      r.pre_prev  = 16'($urandom);
      r.pre_older = 16'($urandom);
      r.pre_out   = $urandom;
      // keep measurements near the last one now and then so the output wanders slowly
      if (r.action == ACT_STEP && $urandom_range(0, 1) == 0) begin
         r.measure  = hist_prev + 16'($signed($urandom_range(0, 400)) - 200);
         r.setpoint = r.measure + 16'($signed($urandom_range(0, 2000)) - 1000);
      end
      if (r.action == ACT_PRELOAD && $urandom_range(0, 1) == 0)
         r.pre_out = $signed($urandom_range(0, 2000000)) - 1000000;
      return r;
   endfunction

   function automatic reg_set_type reset_regs();
      reg_set_type v;
      v[CSR_GAIN_PROP]      = 32'(GAIN_PROP_RESET);
      v[CSR_GAIN_INTEG]     = 32'(GAIN_INTEG_RESET);
      v[CSR_GAIN_DERIV]     = 32'(GAIN_DERIV_RESET);
      v[CSR_OUTPUT_LOW]     = LIMIT_LOW_RESET;
      v[CSR_OUTPUT_HIGH]    = LIMIT_HIGH_RESET;
      v[CSR_INTEG_LOW]      = LIMIT_LOW_RESET;
      v[CSR_INTEG_HIGH]     = LIMIT_HIGH_RESET;
      v[CSR_INTEG_LIMIT_ON] = 32'd0;
      return v;
   endfunction

   task automatic send_req(input pid_req_type r);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid                 <= 1'b1;
      req_if.action                <= r.action;
      req_if.setpoint              <= r.setpoint;
      req_if.measure               <= r.measure;
      req_if.preload_prev_measure  <= r.pre_prev;
      req_if.preload_older_measure <= r.pre_older;
      req_if.preload_output        <= r.pre_out;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_outputs.push_back(advance_pid(r));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_regs(input reg_set_type v);
      csr_index_type idx;
      for (int k = 0; k < 8; k++) begin
         idx = csr_index_type'(k);
         csr_if.valid <= 1'b1;
         csr_if.index <= idx;
         csr_if.data  <= v[k];
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
         case (idx)
            CSR_GAIN_PROP:      gain_p = int'(v[k][15:0]);
            CSR_GAIN_INTEG:     gain_i = int'(v[k][15:0]);
            CSR_GAIN_DERIV:     gain_d = int'(v[k][15:0]);
            CSR_OUTPUT_LOW:     out_lo = int'(v[k]);
            CSR_OUTPUT_HIGH:    out_hi = int'(v[k]);
            CSR_INTEG_LOW:      integ_lo = int'(v[k]);
            CSR_INTEG_HIGH:     integ_hi = int'(v[k]);
            CSR_INTEG_LIMIT_ON: integ_lim_en = v[k][0];
            default: ;
         endcase
      end
      csr_if.valid <= 1'b0;
   endtask

   task automatic pick_limits(output logic [31:0] lo, output logic [31:0] hi);
      int a, b;
      case ($urandom_range(0, 3))
         0: begin
            lo = LIMIT_LOW_RESET;
            hi = LIMIT_HIGH_RESET;
         end
         1: begin
            a  = $urandom;
            b  = $urandom;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
         end
         2: begin
            a  = $urandom_range(0, 3000000);
            b  = $urandom_range(0, 3000000);
            lo = -a;
            hi = b;
         end
         default: begin
            // crossed limits
            a  = $urandom_range(0, 50000);
            lo = a + 1;
            hi = -a;
         end
      endcase
   endtask

   task automatic randomize_regs();
      reg_set_type v;
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 4))
            0: v[k] = 32'd0;
            1: v[k] = 32'd65535;
            2: v[k] = $urandom_range(1, 600);
            3: v[k] = $urandom;
            default: v[k] = 32'd256;
         endcase
      end
      pick_limits(v[CSR_OUTPUT_LOW], v[CSR_OUTPUT_HIGH]);
      pick_limits(v[CSR_INTEG_LOW], v[CSR_INTEG_HIGH]);
      v[CSR_INTEG_LIMIT_ON] = $urandom;
      program_regs(v);
   endtask

   task automatic test_reset_state();
      send_req(step_req(0, 0));
      send_req(step_req(32767, -32768));
      send_req(step_req(-32768, 32767));
   endtask

   task automatic test_preload_extremes();
      reg_set_type v;
      wait_idle();
      v = reset_regs();
      v[CSR_GAIN_PROP]  = 32'd65535;
      v[CSR_GAIN_INTEG] = 32'd65535;
      v[CSR_GAIN_DERIV] = 32'd65535;
      program_regs(v);
      send_req(preload_req(32767, -32768, 32'h7fff_fffa));
      send_req(step_req(32767, -32768));
      send_req(preload_req(-32768, 32767, 32'h8000_0005));
      send_req(step_req(-32768, 32767));
      send_req(step_req(-1, -1));
   endtask

   task automatic test_integ_limit();
      reg_set_type v;
      wait_idle();
      v = reset_regs();
      v[CSR_INTEG_LOW]      = -32'sd100;
      v[CSR_INTEG_HIGH]     = 32'sd100;
      v[CSR_INTEG_LIMIT_ON] = 32'd1;
      program_regs(v);
      send_req(preload_req(0, 0, 0));
      send_req(step_req(1000, 0));
      send_req(step_req(-1000, 0));
      send_req(step_req(50, 0));
   endtask

   task automatic test_crossed_limits();
      reg_set_type v;
      wait_idle();
      v = reset_regs();
      v[CSR_GAIN_DERIV]     = 32'd128;
      v[CSR_OUTPUT_LOW]     = 32'sd1000;
      v[CSR_OUTPUT_HIGH]    = -32'sd1000;
      v[CSR_INTEG_LOW]      = 32'sd50;
      v[CSR_INTEG_HIGH]     = -32'sd50;
      v[CSR_INTEG_LIMIT_ON] = 32'd1;
      program_regs(v);
      send_req(preload_req(0, 0, 0));
      send_req(step_req(10, 0));
      send_req(step_req(-200, 0));
      send_req(step_req(3000, -3000));
   endtask

   task automatic test_zero_gains();
      reg_set_type v;
      wait_idle();
      v = reset_regs();
      v[CSR_GAIN_PROP]  = 32'd0;
      v[CSR_GAIN_INTEG] = 32'd0;
      v[CSR_GAIN_DERIV] = 32'd300;
      program_regs(v);
      send_req(preload_req(100, -100, 7));
      send_req(step_req(20000, -5000));
      send_req(step_req(-32768, 32767));
   endtask

   task automatic test_backpressure();
      reg_set_type v;
      wait_idle();
      v = reset_regs();
      v[CSR_GAIN_DERIV] = 32'd64;
      program_regs(v);
      idle_pct      = 0;
      long_hold_req = 1'b1;
      repeat (40) send_req(rand_pid_req());
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_idle();
         randomize_regs();
         idle_pct = (ph == N_PHASES - 1) ? 0 : (ph % 3) * 15;
         repeat (PHASE_ITEMS) send_req(rand_pid_req());
      end
   endtask

   task automatic finish_run();
      req_if.valid <= 1'b0;
      idle_pct = 0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (errors == 0 && pending_outputs.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
         rsp_if.ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         hold_left = $urandom_range(0, 8);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_outputs
      pid_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t control_out: expected no result actual %0d",
                     $time, rsp_if.control_out);
            errors++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_if.control_out !== want.control_out) begin
               $display("%0t control_out: expected %0d actual %0d",
                        $time, want.control_out, rsp_if.control_out);
               errors++;
            end
            if (rsp_if.clamp_status !== want.status) begin
               $display("%0t clamp_status: expected %0d actual %0d",
                        $time, want.status, rsp_if.clamp_status);
               errors++;
            end
            if (rsp_if.integ_clamped !== want.integ_clamped) begin
               $display("%0t integ_clamped: expected %0d actual %0d",
                        $time, want.integ_clamped, rsp_if.integ_clamped);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset                        <= 1'b1;
      req_if.valid                 <= 1'b0;
      req_if.action                <= ACT_STEP;
      req_if.setpoint              <= '0;
      req_if.measure               <= '0;
      req_if.preload_prev_measure  <= '0;
      req_if.preload_older_measure <= '0;
      req_if.preload_output        <= '0;
      csr_if.valid                 <= 1'b0;
      csr_if.index                 <= CSR_GAIN_PROP;
      csr_if.data                  <= '0;
      hist_prev    = '0;
      hist_older   = '0;
      held_out     = 0;
      gain_p       = int'(GAIN_PROP_RESET);
      gain_i       = int'(GAIN_INTEG_RESET);
      gain_d       = int'(GAIN_DERIV_RESET);
      out_lo       = int'(LIMIT_LOW_RESET);
      out_hi       = int'(LIMIT_HIGH_RESET);
      integ_lo     = int'(LIMIT_LOW_RESET);
      integ_hi     = int'(LIMIT_HIGH_RESET);
      integ_lim_en = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_preload_extremes();
      test_integ_limit();
      test_crossed_limits();
      test_zero_gains();
      test_backpressure();
      test_random_traffic();
      finish_run();
   end

endmodule

/* filelist.f */
rtl/core/vpid_pkg.sv
rtl/core/vpid_intf.sv
rtl/core/velocity_pid_controller.sv
bench/tb_top.sv
